// File: src/sse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the sprite scanline evaluation block.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Memory geometry
  localparam int ADDR_W = 8;
  localparam int BYTE_W = 8;

  // Scan limits
  localparam int MAX_SPRITES  = 8;
  localparam int SCAN_ENTRIES = 64;
  localparam int COPY_BYTES   = 8;

  // Counter widths; all but FC_W are derived from the scan limits
  localparam int CNT_W = $clog2(SCAN_ENTRIES + 1);
  localparam int HC_W  = $clog2(MAX_SPRITES + 2);
  localparam int SEL_W = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int FC_W  = 4;

  // Function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;

  // Byte-level constants
  localparam logic [BYTE_W-1:0] ATTR_READ_MASK = 8'hE3;
  localparam logic [BYTE_W-1:0] PRERENDER_LINE = 8'hFF;
  localparam logic [BYTE_W-1:0] ERASE_VALUE    = 8'hFF;
  localparam logic [1:0]        ATTR_BYTE      = 2'd2;
  localparam logic [2:0]        FETCH_LAST     = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_SCAN,
    ST_EMIT,
    ST_FETCH
  } state_t;

  // Memory write request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              sprite_valid;
    logic [BYTE_W-1:0] sprite_y;
    logic [BYTE_W-1:0] sprite_tile;
    logic [BYTE_W-1:0] sprite_attr;
    logic [BYTE_W-1:0] sprite_x;
    logic              sprite_zero;
    logic [FC_W-1:0]   found_count;
    logic              overflow;
    logic              last;
  } res_t;

endpackage

// File: src/sprite_scanline_evaluation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_scanline_evaluation
// Sprite attribute memory with byte access and per-line sprite selection.
// ----------------------------------------------------------------------------
// Write: written to memory when accepted, no result. Read: the byte is read in the read state
// and its result strobed from the output register. Evaluate: row copy when the start index is 8
// or more, then a scan (one memory read per entry), then a state to settle the count (the no-hit
// result leaves here), then a byte fetch for each selected sprite (one byte read a cycle).
// Results leave an output register and cannot be stalled.
// After reset the memory is erased to 0xFF with busy high.
module sprite_scanline_evaluation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_func,
  input  logic [sse_pkg::ADDR_W-1:0] in_oam_index,
  input  logic [sse_pkg::BYTE_W-1:0] in_oam_data,
  input  logic [sse_pkg::BYTE_W-1:0] in_line,
  input  logic                       in_prerender,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  output logic                       out_strobe,
  output logic [sse_pkg::BYTE_W-1:0] out_read_data,
  output logic                       out_sprite_valid,
  output logic [sse_pkg::BYTE_W-1:0] out_sprite_y,
  output logic [sse_pkg::BYTE_W-1:0] out_sprite_tile,
  output logic [sse_pkg::BYTE_W-1:0] out_sprite_attr,
  output logic [sse_pkg::BYTE_W-1:0] out_sprite_x,
  output logic                       out_sprite_zero,
  output logic [sse_pkg::FC_W-1:0]   out_found_count,
  output logic                       out_overflow,
  output logic                       out_last
);

  import sse_pkg::*;

  logic              tall_r;
  logic              strobe_r;
  res_t              res_r;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              res_valid;
  res_t              res;

  // Sprite height register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tall_r <= 1'b0;
    end else if (cfg_we) begin
      tall_r <= cfg_wdata;
    end
  end

  sse_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sse_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_func      (in_func),
    .in_oam_index (in_oam_index),
    .in_oam_data  (in_oam_data),
    .in_line      (in_line),
    .in_prerender (in_prerender),
    .tall         (tall_r),
    .busy         (busy),
    .ram_wr       (ram_wr),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Output register: strobe for one cycle per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_read_data    = res_r.read_data;
  assign out_sprite_valid = res_r.sprite_valid;
  assign out_sprite_y     = res_r.sprite_y;
  assign out_sprite_tile  = res_r.sprite_tile;
  assign out_sprite_attr  = res_r.sprite_attr;
  assign out_sprite_x     = res_r.sprite_x;
  assign out_sprite_zero  = res_r.sprite_zero;
  assign out_found_count  = res_r.found_count;
  assign out_overflow     = res_r.overflow;
  assign out_last         = res_r.last;

  // A transfer always comes from work done while busy
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // A read returns a single result, marked last
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_READ) |-> ##2 (out_strobe && out_last))
    else $error("read result missing or not last");

  // A write gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_WRITE) |-> ##2 !out_strobe)
    else $error("write produced a result");

  // Results without a sprite are always single
  a_nosprite_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_sprite_valid) |-> out_last)
    else $error("non-sprite result not marked last");

  // Overflow only with a saturated hit count
  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_overflow) |-> (out_found_count == FC_W'(MAX_SPRITES + 1)))
    else $error("overflow with unsaturated count");

endmodule

// File: src/sse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sse_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/sse_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_engine
// Sequencer around the sprite memory: erase after reset, byte access,
// row copy, entry scan and readout of the selected sprites.
// ----------------------------------------------------------------------------
module sse_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 in_func,
  input  logic [sse_pkg::ADDR_W-1:0] in_oam_index,
  input  logic [sse_pkg::BYTE_W-1:0] in_oam_data,
  input  logic [sse_pkg::BYTE_W-1:0] in_line,
  input  logic                       in_prerender,
  input  logic                       tall,
  output logic                       busy,
  output sse_pkg::ram_wr_t           ram_wr,
  output logic [sse_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [sse_pkg::BYTE_W-1:0] ram_rdata,
  output logic                       res_valid,
  output sse_pkg::res_t              res
);

  import sse_pkg::*;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0] eval_y_r, eval_y_nxt;
  logic              pre_r, pre_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              chk_r, chk_nxt;
  logic [ADDR_W-1:0] chk_addr_r, chk_addr_nxt;
  logic [HC_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [ADDR_W-1:0] sel_r [MAX_SPRITES];
  logic [ADDR_W-1:0] sel_nxt [MAX_SPRITES];
  logic [SEL_W-1:0]  k_r, k_nxt;
  logic [2:0]        fb_r, fb_nxt;
  logic [BYTE_W-1:0] y_r, y_nxt;
  logic [BYTE_W-1:0] tile_r, tile_nxt;
  logic [BYTE_W-1:0] attr_r, attr_nxt;

  logic              accept;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W:0]   diff;
  logic              in_range;
  logic [HC_W-1:0]   n_sel;
  logic              sel_last;
  logic              ovf;
  logic [ADDR_W-1:0] cur_sel;

  // Shared decode
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign scan_addr = idx_r + ADDR_W'({cnt_r, 2'b00});
  assign diff      = {1'b0, eval_y_r} - {1'b0, ram_rdata};
  assign in_range  = !diff[ADDR_W] &&
                     (tall ? (diff[7:4] == 4'd0) : (diff[7:3] == 5'd0));
  assign n_sel     = (hit_cnt_r > HC_W'(MAX_SPRITES)) ? HC_W'(MAX_SPRITES) : hit_cnt_r;
  assign sel_last  = (HC_W'(k_r) == (n_sel - HC_W'(1)));
  assign ovf       = (hit_cnt_r > HC_W'(MAX_SPRITES)) && !pre_r;
  assign cur_sel   = sel_r[k_r];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(2**ADDR_W - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_READ: state_nxt = ST_READ;
            FUNC_EVAL: state_nxt = (in_oam_index[7:3] != 5'd0) ? ST_COPY : ST_SCAN;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_COPY: begin
        if (cnt_r == CNT_W'(COPY_BYTES)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == CNT_W'(SCAN_ENTRIES)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        state_nxt = (hit_cnt_r == '0) ? ST_IDLE : ST_FETCH;
      end
      ST_FETCH: begin
        if (fb_r == FETCH_LAST && sel_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    idx_nxt      = idx_r;
    eval_y_nxt   = eval_y_r;
    pre_nxt      = pre_r;
    cnt_nxt      = cnt_r;
    chk_nxt      = chk_r;
    chk_addr_nxt = chk_addr_r;
    hit_cnt_nxt  = hit_cnt_r;
    sel_nxt      = sel_r;
    k_nxt        = k_r;
    fb_nxt       = fb_r;
    y_nxt        = y_r;
    tile_nxt     = tile_r;
    attr_nxt     = attr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        // Latch the item and reset the scan
        if (accept) begin
          idx_nxt     = in_oam_index;
          eval_y_nxt  = in_prerender ? PRERENDER_LINE : in_line;
          pre_nxt     = in_prerender;
          cnt_nxt     = '0;
          chk_nxt     = 1'b0;
          hit_cnt_nxt = '0;
          k_nxt       = '0;
          fb_nxt      = '0;
        end
      end
      ST_COPY: begin
        cnt_nxt = (cnt_r == CNT_W'(COPY_BYTES)) ? '0 : cnt_r + CNT_W'(1);
      end
      ST_SCAN: begin
        // Issue one entry read per cycle, compare its Y in the next cycle
        if (cnt_r != CNT_W'(SCAN_ENTRIES)) begin
          cnt_nxt      = cnt_r + CNT_W'(1);
          chk_nxt      = 1'b1;
          chk_addr_nxt = scan_addr;
        end else begin
          chk_nxt = 1'b0;
        end
        if (chk_r && in_range && (hit_cnt_r <= HC_W'(MAX_SPRITES))) begin
          if (hit_cnt_r < HC_W'(MAX_SPRITES)) begin
            sel_nxt[hit_cnt_r[SEL_W-1:0]] = chk_addr_r;
          end
          hit_cnt_nxt = hit_cnt_r + HC_W'(1);
        end
      end
      ST_FETCH: begin
        // Collect the four bytes of the current sprite
        case (fb_r)
          3'd1:    y_nxt    = ram_rdata;
          3'd2:    tile_nxt = ram_rdata;
          3'd3:    attr_nxt = ram_rdata;
          default: ;
        endcase
        if (fb_r == FETCH_LAST) begin
          fb_nxt = '0;
          k_nxt  = k_r + SEL_W'(1);
        end else begin
          fb_nxt = fb_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Memory ports and result
  always_comb begin
    ram_wr    = '0;
    ram_raddr = in_oam_index;
    res_valid = 1'b0;
    res       = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_wr = '{we: 1'b1, addr: clr_cnt_r, data: ERASE_VALUE};
      end
      ST_IDLE: begin
        if (accept && in_func == FUNC_WRITE) begin
          ram_wr = '{we: 1'b1, addr: in_oam_index, data: in_oam_data};
        end
      end
      ST_READ: begin
        res_valid     = 1'b1;
        res.read_data = (idx_r[1:0] == ATTR_BYTE) ? (ram_rdata & ATTR_READ_MASK) : ram_rdata;
        res.last      = 1'b1;
      end
      ST_COPY: begin
        // Read bytes 0..7, write each one in the next cycle onto the start row
        ram_raddr = ADDR_W'(cnt_r[2:0]);
        if (cnt_r != '0) begin
          ram_wr = '{we: 1'b1,
                     addr: {idx_r[7:3], 3'(cnt_r - CNT_W'(1))},
                     data: ram_rdata};
        end
      end
      ST_SCAN: begin
        ram_raddr = scan_addr;
      end
      ST_EMIT: begin
        if (hit_cnt_r == '0) begin
          res_valid = 1'b1;
          res.last  = 1'b1;
        end
      end
      ST_FETCH: begin
        ram_raddr = cur_sel + ADDR_W'(fb_r);
        if (fb_r == FETCH_LAST) begin
          res_valid        = 1'b1;
          res.sprite_valid = 1'b1;
          res.sprite_y     = y_r;
          res.sprite_tile  = tile_r;
          res.sprite_attr  = attr_r;
          res.sprite_x     = ram_rdata;
          res.sprite_zero  = (cur_sel[7:2] == 6'd0);
          res.found_count  = FC_W'(hit_cnt_r);
          res.overflow     = ovf;
          res.last         = sel_last;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      cnt_r     <= '0;
      chk_r     <= 1'b0;
      hit_cnt_r <= '0;
      k_r       <= '0;
      fb_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      cnt_r     <= cnt_nxt;
      chk_r     <= chk_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      k_r       <= k_nxt;
      fb_r      <= fb_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    eval_y_r   <= eval_y_nxt;
    pre_r      <= pre_nxt;
    chk_addr_r <= chk_addr_nxt;
    sel_r      <= sel_nxt;
    y_r        <= y_nxt;
    tile_r     <= tile_nxt;
    attr_r     <= attr_nxt;
  end

endmodule
